// ===== rtl/crtf_pkg.sv =====
// Shared types and constants for the register transfer and flag unit.
// Holds the register-set struct, operation codes and reset values.
// No dependencies.
package crtf_pkg;

   typedef struct packed {
      logic [15:0] acc;
      logic [15:0] xidx;
      logic [15:0] yidx;
      logic [15:0] stack_ptr;
      logic [15:0] direct_page;
      logic [7:0]  status;
      logic        emul;
   } regs_type;

   localparam int MODE_W = 5;
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 6;
   localparam int RSP_TDATA_W = 96;
   localparam int RSP_USED_W = 89;

   // operation codes
   localparam logic [MODE_W-1:0] OP_NOP = 5'd0;
   localparam logic [MODE_W-1:0] OP_XBA = 5'd1;
   localparam logic [MODE_W-1:0] OP_XCE = 5'd2;
   localparam logic [MODE_W-1:0] OP_CLC = 5'd3;
   localparam logic [MODE_W-1:0] OP_SEC = 5'd4;
   localparam logic [MODE_W-1:0] OP_CLI = 5'd5;
   localparam logic [MODE_W-1:0] OP_SEI = 5'd6;
   localparam logic [MODE_W-1:0] OP_CLV = 5'd7;
   localparam logic [MODE_W-1:0] OP_CLD = 5'd8;
   localparam logic [MODE_W-1:0] OP_SED = 5'd9;
   localparam logic [MODE_W-1:0] OP_REP = 5'd10;
   localparam logic [MODE_W-1:0] OP_SEP = 5'd11;
   localparam logic [MODE_W-1:0] OP_TSC = 5'd12;
   localparam logic [MODE_W-1:0] OP_TCD = 5'd13;
   localparam logic [MODE_W-1:0] OP_TDC = 5'd14;
   localparam logic [MODE_W-1:0] OP_TXA = 5'd15;
   localparam logic [MODE_W-1:0] OP_TYA = 5'd16;
   localparam logic [MODE_W-1:0] OP_TXY = 5'd17;
   localparam logic [MODE_W-1:0] OP_TAY = 5'd18;
   localparam logic [MODE_W-1:0] OP_TAX = 5'd19;
   localparam logic [MODE_W-1:0] OP_TYX = 5'd20;
   localparam logic [MODE_W-1:0] OP_TCS = 5'd21;
   localparam logic [MODE_W-1:0] OP_TSX = 5'd22;
   localparam logic [MODE_W-1:0] OP_TXS = 5'd23;

   // status bit positions
   localparam int FLAG_C_BIT = 0;
   localparam int FLAG_Z_BIT = 1;
   localparam int FLAG_I_BIT = 2;
   localparam int FLAG_D_BIT = 3;
   localparam int FLAG_X_BIT = 4;
   localparam int FLAG_M_BIT = 5;
   localparam int FLAG_V_BIT = 6;
   localparam int FLAG_N_BIT = 7;

   localparam logic [7:0] STATUS_MX = 8'h30;
   localparam logic [7:0] STACK_PAGE = 8'h01;

   localparam regs_type REGS_RESET = '{
      acc:         16'h0000,
      xidx:        16'h0000,
      yidx:        16'h0000,
      stack_ptr:   16'h01FF,
      direct_page: 16'h0000,
      status:      8'h34,
      emul:        1'b1
   };

endpackage

// ===== rtl/crtf_exec.sv =====
// Next register set for one register-only instruction.
// Pure combinational; uses crtf_pkg for the register struct and op codes.
module crtf_exec (
   input  crtf_pkg::regs_type               cur,
   input  logic [crtf_pkg::MODE_W-1:0]      mode,
   input  logic                             wide,
   input  logic [7:0]                       immediate,
   output crtf_pkg::regs_type               nxt
);

   function automatic logic [15:0] xfer_value(input logic [15:0] src,
                                              input logic [15:0] dst,
                                              input logic        w);
      return w ? src : {dst[15:8], src[7:0]};
   endfunction

   function automatic logic [7:0] set_nz(input logic [7:0]  p,
                                         input logic [15:0] v,
                                         input logic        w);
      logic n;
      logic z;
      n = w ? v[15] : v[7];
      z = w ? (v == 16'h0000) : (v[7:0] == 8'h00);
      return {n, p[6:2], z, p[0]};
   endfunction

   crtf_pkg::regs_type r;
   logic               trim;

   always_comb begin
      r    = cur;
      trim = 1'b0;
      unique case (mode)
         crtf_pkg::OP_XBA: begin
            r.acc    = {cur.acc[7:0], cur.acc[15:8]};
            r.status = set_nz(cur.status, {8'h00, cur.acc[15:8]}, 1'b0);
         end
         crtf_pkg::OP_XCE: begin
            r.status[crtf_pkg::FLAG_C_BIT] = cur.emul;
            r.emul = cur.status[crtf_pkg::FLAG_C_BIT];
            if (r.emul) begin
               r.status         = r.status | crtf_pkg::STATUS_MX;
               r.stack_ptr[15:8] = crtf_pkg::STACK_PAGE;
            end
            trim = 1'b1;
         end
         crtf_pkg::OP_CLC: r.status[crtf_pkg::FLAG_C_BIT] = 1'b0;
         crtf_pkg::OP_SEC: r.status[crtf_pkg::FLAG_C_BIT] = 1'b1;
         crtf_pkg::OP_CLI: r.status[crtf_pkg::FLAG_I_BIT] = 1'b0;
         crtf_pkg::OP_SEI: r.status[crtf_pkg::FLAG_I_BIT] = 1'b1;
         crtf_pkg::OP_CLV: r.status[crtf_pkg::FLAG_V_BIT] = 1'b0;
         crtf_pkg::OP_CLD: r.status[crtf_pkg::FLAG_D_BIT] = 1'b0;
         crtf_pkg::OP_SED: r.status[crtf_pkg::FLAG_D_BIT] = 1'b1;
         crtf_pkg::OP_REP, crtf_pkg::OP_SEP: begin
            r.status = (mode == crtf_pkg::OP_REP) ? (cur.status & ~immediate)
                                                  : (cur.status | immediate);
            if (cur.emul) begin
               r.status = r.status | crtf_pkg::STATUS_MX;
            end
            trim = 1'b1;
         end
         crtf_pkg::OP_TSC: begin
            r.acc    = cur.stack_ptr;
            r.status = set_nz(cur.status, r.acc, 1'b1);
         end
         crtf_pkg::OP_TCD: begin
            r.direct_page = cur.acc;
            r.status      = set_nz(cur.status, r.direct_page, 1'b1);
         end
         crtf_pkg::OP_TDC: begin
            r.acc    = cur.direct_page;
            r.status = set_nz(cur.status, r.acc, 1'b1);
         end
         crtf_pkg::OP_TXA: begin
            r.acc    = xfer_value(cur.xidx, cur.acc, wide);
            r.status = set_nz(cur.status, r.acc, wide);
         end
         crtf_pkg::OP_TYA: begin
            r.acc    = xfer_value(cur.yidx, cur.acc, wide);
            r.status = set_nz(cur.status, r.acc, wide);
         end
         crtf_pkg::OP_TXY: begin
            r.yidx   = xfer_value(cur.xidx, cur.yidx, wide);
            r.status = set_nz(cur.status, r.yidx, wide);
         end
         crtf_pkg::OP_TAY: begin
            r.yidx   = xfer_value(cur.acc, cur.yidx, wide);
            r.status = set_nz(cur.status, r.yidx, wide);
         end
         crtf_pkg::OP_TAX: begin
            r.xidx   = xfer_value(cur.acc, cur.xidx, wide);
            r.status = set_nz(cur.status, r.xidx, wide);
         end
         crtf_pkg::OP_TYX: begin
            r.xidx   = xfer_value(cur.yidx, cur.xidx, wide);
            r.status = set_nz(cur.status, r.xidx, wide);
         end
         crtf_pkg::OP_TCS: begin
            r.stack_ptr = xfer_value(cur.acc, cur.stack_ptr, !cur.emul);
         end
         crtf_pkg::OP_TSX: begin
            r.xidx   = xfer_value(cur.stack_ptr, cur.xidx, wide);
            r.status = set_nz(cur.status, r.xidx, wide);
         end
         crtf_pkg::OP_TXS: begin
            r.stack_ptr = xfer_value(cur.xidx, cur.stack_ptr, !cur.emul);
         end
         default: begin
            // nop and unused codes: hold everything
         end
      endcase
      // with x set, index high bytes drop after a mode change
      if (trim && r.status[crtf_pkg::FLAG_X_BIT]) begin
         r.xidx[15:8] = 8'h00;
         r.yidx[15:8] = 8'h00;
      end
      nxt = r;
   end

endmodule

// ===== rtl/cpu_register_transfer_flag_unit.sv =====
// Top level of the register transfer and flag unit: register file, result register.
// Depends on crtf_pkg and crtf_exec.
//
// Usage:
//   req channel carries one register-only instruction per transaction:
//   req_tuser holds the op code and width select, req_tdata the REP/SEP mask.
//   rsp channel returns the full register set after each instruction.
//   Latency: the result is valid the cycle after the request is taken.
//   Throughput: one instruction per cycle while the receiver keeps up; the register
//   file and the result register are both loaded at the accepting edge, so the next
//   instruction sees the updated registers straight away.
//   req_tready is high whenever the result register is empty or is being
//   taken in the same cycle; a stalled receiver holds the result and blocks
//   new requests until it is taken.
//   Reset (synchronous) loads the 65816 reset state: A, X, Y, D zero,
//   S 0x01FF, P 0x34, emulation bit set, and empties the result register.
module cpu_register_transfer_flag_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] immediate
   input  logic [crtf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [4:0] mode, [5] wide
   input  logic [crtf_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] acc_out, [31:16] xidx_out, [47:32] yidx_out, [63:48] stack_out,
   // [79:64] direct_out, [87:80] status_out, [88] emul_out, [95:89] zero
   output logic [crtf_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   crtf_pkg::regs_type regs_ff;
   crtf_pkg::regs_type regs_in;
   logic               rsp_valid_ff;
   logic [crtf_pkg::RSP_USED_W-1:0] rsp_data_ff;
   logic               req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   crtf_exec u_exec (
      .cur       (regs_ff),
      .mode      (req_tuser[crtf_pkg::MODE_W-1:0]),
      .wide      (req_tuser[crtf_pkg::MODE_W]),
      .immediate (req_tdata),
      .nxt       (regs_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= crtf_pkg::REGS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            regs_ff      <= regs_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: load on every taken transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= {regs_in.emul, regs_in.status, regs_in.direct_page,
                         regs_in.stack_ptr, regs_in.yidx, regs_in.xidx, regs_in.acc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(crtf_pkg::RSP_TDATA_W - crtf_pkg::RSP_USED_W){1'b0}}, rsp_data_ff};

   // result register empties after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // never overwrite a stalled result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

   // registers move only on a taken transaction
   assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(regs_ff))
      else $error("register set changed without a transaction");

   // emulation mode keeps m and x set and S in page one
   assert property (@(posedge clock) disable iff (reset)
      regs_ff.emul |-> (regs_ff.status[crtf_pkg::FLAG_M_BIT]
                        && regs_ff.status[crtf_pkg::FLAG_X_BIT]
                        && regs_ff.stack_ptr[15:8] == crtf_pkg::STACK_PAGE))
      else $error("emulation invariant broken");

endmodule
